@@ sv/tlfd_pkg.sv @@
// Package for the type-length frame deframer.
// Holds the header layout constants and the result item struct.
// No dependencies.
`default_nettype none

package tlfd_pkg;

  localparam int HEADER_BYTES = 5;
  localparam int LEN_BYTES    = 4;
  localparam int CNT_W        = 4;
  localparam int LEN_W        = 32;

  typedef struct packed {
    logic [7:0] frame_kind;
    logic [7:0] body_byte;
    logic       frame_end;
    logic       empty_frame;
  } tlfd_res_t;

endpackage

`default_nettype wire

@@ sv/type_length_frame_deframer.sv @@
// Type-length frame deframer top level: parser plus output buffer.
// Throughput: one stream byte per cycle while the output is not stalled, including across frames.
// A result is registered into the output stage, or into the skid stage under a stall, as its byte is taken.
// A two-entry output stage keeps in_ready registered; a stall costs no bytes.
// Reset (rst, synchronous) clears header and body counters and both stages.
`default_nettype none

module type_length_frame_deframer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] stream_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      frame_kind,
  output logic [7:0]      body_byte,
  output logic            frame_end,
  output logic            empty_frame
);
  import tlfd_pkg::*;

  logic      accept;
  logic      res_valid;
  tlfd_res_t res;
  tlfd_res_t out_data;

  assign accept = in_valid && in_ready;

  tlfd_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .stream_byte (stream_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  tlfd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign frame_kind  = out_data.frame_kind;
  assign body_byte   = out_data.body_byte;
  assign frame_end   = out_data.frame_end;
  assign empty_frame = out_data.empty_frame;

endmodule

`default_nettype wire

@@ sv/tlfd_parse.sv @@
// Frame parser: header collection and body counting, one item per cycle.
// Produces at most one result per accepted item, combinationally.
// Depends on tlfd_pkg.
`default_nettype none

module tlfd_parse (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       stream_byte,
  output logic                  res_valid,
  output tlfd_pkg::tlfd_res_t   res
);
  import tlfd_pkg::*;

  localparam logic [CNT_W-1:0] HdrLast = CNT_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] LenLast = CNT_W'(LEN_BYTES);

  logic [CNT_W-1:0] header_seen, header_seen_next, hs_inc;
  logic             in_body, in_body_next;
  logic [7:0]       kind_hold, kind_hold_next;
  logic [LEN_W-1:0] body_total, body_total_next;
  logic [LEN_W-1:0] body_seen, body_seen_next, seen_inc;
  logic             last;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_seen <= '0;
      in_body     <= 1'b0;
      kind_hold   <= '0;
      body_total  <= '0;
      body_seen   <= '0;
    end else begin
      header_seen <= header_seen_next;
      in_body     <= in_body_next;
      kind_hold   <= kind_hold_next;
      body_total  <= body_total_next;
      body_seen   <= body_seen_next;
    end
  end

  always_comb begin
    header_seen_next = header_seen;
    in_body_next     = in_body;
    kind_hold_next   = kind_hold;
    body_total_next  = body_total;
    body_seen_next   = body_seen;
    res_valid        = 1'b0;
    res              = '0;
    seen_inc         = body_seen + LEN_W'(1);
    last             = (seen_inc == body_total);
    hs_inc           = header_seen + CNT_W'(1);
    if (accept) begin
      if (in_body) begin
        res_valid      = 1'b1;
        res.frame_kind = kind_hold;
        res.body_byte  = stream_byte;
        res.frame_end  = last;
        body_seen_next = seen_inc;
        if (last) begin
          in_body_next     = 1'b0;
          header_seen_next = '0;
        end
      end else begin
        if (header_seen == '0) begin
          kind_hold_next  = stream_byte;
          body_total_next = '0;
        end else if (header_seen <= LenLast) begin
          body_total_next = {body_total[LEN_W-9:0], stream_byte};
        end
        if (hs_inc >= HdrLast) begin
          header_seen_next = '0;
          body_seen_next   = '0;
          if (body_total_next == '0) begin
            res_valid       = 1'b1;
            res.frame_kind  = kind_hold_next;
            res.frame_end   = 1'b1;
            res.empty_frame = 1'b1;
          end else begin
            in_body_next = 1'b1;
          end
        end else begin
          header_seen_next = hs_inc;
        end
      end
    end
  end

  a_body_hdr_idle: assert property (@(posedge clk) disable iff (rst)
    in_body |-> header_seen == '0)
    else $error("header counter running during body");

  a_hdr_bound: assert property (@(posedge clk) disable iff (rst)
    header_seen < HdrLast)
    else $error("header counter past header length");

  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.empty_frame |-> res.frame_end && res.body_byte == 8'd0 && !in_body)
    else $error("malformed empty-frame result");

  a_body_count: assert property (@(posedge clk) disable iff (rst)
    in_body |-> body_seen < body_total)
    else $error("body count overran length");

endmodule

`default_nettype wire

@@ sv/tlfd_out_buf.sv @@
// Output register with a skid stage for result items.
// Keeps input ready a registered signal independent of output ready.
// Depends on tlfd_pkg.
`default_nettype none

module tlfd_out_buf (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  tlfd_pkg::tlfd_res_t  push_data,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output tlfd_pkg::tlfd_res_t  out_data
);
  import tlfd_pkg::*;

  logic      skid_valid;
  tlfd_res_t skid;
  logic      out_free;

  assign in_ready = !skid_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid : push_data;
    end
    if (!out_free && push) begin
      skid <= push_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while output is empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("item pushed while skid full");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> !skid_valid && out_valid)
    else $error("skid item not moved to output");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for type_length_frame_deframer: drives framed byte streams and
// checks every delivered body byte and every empty-frame item against a predictor.
// Depends on tlfd_pkg and the deframer RTL.
`default_nettype none

module tb_top;
  import tlfd_pkg::*;

  class deframe_scoreboard;
    logic [CNT_W-1:0] hdr_cnt;
    bit               in_body;
    logic [7:0]       kind;
    logic [LEN_W-1:0] body_len;
    logic [LEN_W-1:0] body_cnt;
    tlfd_res_t        pending_results[$];
    int               errors;

    function new();
      hdr_cnt  = '0;
      in_body  = 1'b0;
      kind     = '0;
      body_len = '0;
      body_cnt = '0;
      errors   = 0;
    endfunction

    function void take_stream_byte(logic [7:0] b);
      tlfd_res_t r;
      if (in_body) begin
        r.frame_kind  = kind;
        r.body_byte   = b;
        r.frame_end   = (body_cnt + 32'd1) == body_len;
        r.empty_frame = 1'b0;
        body_cnt = body_cnt + 32'd1;
        if (r.frame_end) begin
          in_body = 1'b0;
          hdr_cnt = '0;
        end
        pending_results = {pending_results, r};
        return;
      end
      if (hdr_cnt == 0) begin
        kind     = b;
        body_len = '0;
      end else if (hdr_cnt <= LEN_BYTES) begin
        body_len = {body_len[LEN_W-9:0], b};
      end
      hdr_cnt = hdr_cnt + 1'b1;
      if (hdr_cnt >= HEADER_BYTES) begin
        hdr_cnt  = '0;
        body_cnt = '0;
        if (body_len == 0) begin
          r.frame_kind  = kind;
          r.body_byte   = 8'h00;
          r.frame_end   = 1'b1;
          r.empty_frame = 1'b1;
          pending_results = {pending_results, r};
        end else begin
          in_body = 1'b1;
        end
      end
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_delivery(tlfd_res_t got);
      tlfd_res_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual kind %h byte %h end %b empty %b",
                 $time, got.frame_kind, got.body_byte, got.frame_end, got.empty_frame);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      compare_field("frame_kind", exp_r.frame_kind, got.frame_kind);
      compare_field("body_byte", exp_r.body_byte, got.body_byte);
      compare_field("frame_end", {7'd0, exp_r.frame_end}, {7'd0, got.frame_end});
      compare_field("empty_frame", {7'd0, exp_r.empty_frame}, {7'd0, got.empty_frame});
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] stream_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] frame_kind;
  logic [7:0] body_byte;
  logic       frame_end;
  logic       empty_frame;

  deframe_scoreboard sb = new();
  int  bytes_sent   = 0;
  bit  tx_idle_on   = 1'b1;
  bit  rx_idle_on   = 1'b1;

  type_length_frame_deframer dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_kind  (frame_kind),
    .body_byte   (body_byte),
    .frame_end   (frame_end),
    .empty_frame (empty_frame)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    bit took;
    if (bytes_sent % 64 == 0) begin
      tx_idle_on = $urandom_range(0, 3) != 0;
    end
    gap = tx_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    sb.take_stream_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] kind, input logic [31:0] len,
                            input int body_count, input bit fixed_body,
                            input logic [7:0] fill);
    send_byte(kind);
    send_byte(len[31:24]);
    send_byte(len[23:16]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (int i = 1 + LEN_BYTES; i < HEADER_BYTES; i++) begin
      send_byte(8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < body_count; i++) begin
      send_byte(fixed_body ? fill : 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_random_frame();
    int          pick;
    logic [31:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      len = 0;
    end else if (pick < 85) begin
      len = $urandom_range(1, 8);
    end else if (pick < 97) begin
      len = $urandom_range(9, 40);
    end else begin
      len = $urandom_range(250, 270);
    end
    send_frame(8'($urandom_range(0, 255)), len, len, 1'b0, 8'h00);
  endtask

  initial begin
    int taken;
    bit held;
    tlfd_res_t got;
    bit seen;
    int stall;
    taken = 0;
    held  = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && taken == 400) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if (taken % 64 == 0) begin
        rx_idle_on = $urandom_range(0, 3) != 0;
      end
      stall = rx_idle_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        seen = out_valid;
        got  = '{frame_kind, body_byte, frame_end, empty_frame};
        @(posedge clk);
      end while (!seen);
      sb.check_delivery(got);
      taken++;
    end
  end

  initial begin
    logic [31:0] huge_len;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    stream_byte <= 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_frame(8'h00, 32'd0, 0, 1'b1, 8'h00);
    send_frame(8'hFF, 32'd0, 0, 1'b1, 8'h00);
    send_frame(8'hA5, 32'd1, 1, 1'b1, 8'hFF);
    send_frame(8'h5A, 32'd2, 1, 1'b1, 8'h00);
    send_byte(8'hFF);

    while (bytes_sent < 1520) send_random_frame();

    // hold a huge body open; its end is never reached
    huge_len = $urandom | 32'h8000_0000;
    send_frame(8'($urandom_range(0, 255)), huge_len, 20, 1'b0, 8'h00);
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
